// ----- rtl/lkvc_pkg.sv -----
package lkvc_pkg;

  localparam int unsigned ENTRIES    = 16;
  localparam int unsigned VALUE_BITS = 64;
  localparam int unsigned KEY_BITS   = 32;
  localparam int unsigned CAP_BITS   = 5;
  localparam int unsigned OUT_BITS   = 64;
  localparam int unsigned AGE_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W      = $clog2(ENTRIES + 1);
  localparam int unsigned CAP_RESET  = 16;

  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_PUT = 1'b1;

  // broadcast to every entry for one word
  typedef struct packed {
    logic                  clr;
    logic                  upd;
    logic                  wr_val;
    logic                  ld_key;
    logic [AGE_W:0]        thr;
    logic [AGE_W-1:0]      lru_age;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } lkvc_cmd_t;

  typedef struct packed {
    logic                  valid;
    logic                  match;
    logic                  victim;
    logic [AGE_W-1:0]      age;
    logic [VALUE_BITS-1:0] value;
  } lkvc_stat_t;

  // zero reads as one, above ENTRIES saturates
  function automatic logic [CNT_W-1:0] eff_cap(logic [CAP_BITS-1:0] c);
    int v;
    v = int'(c);
    if (v == 0) v = 1;
    if (v > int'(ENTRIES)) v = int'(ENTRIES);
    return CNT_W'(v);
  endfunction

endpackage

// ----- rtl/lkvc_entry.sv -----
module lkvc_entry (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lkvc_pkg::lkvc_cmd_t cmd_i,
  input  logic               sel_i,
  output lkvc_pkg::lkvc_stat_t stat_o
);
  import lkvc_pkg::*;

  logic                  valid_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] value_q;
  logic [AGE_W-1:0]      age_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.clr) begin
      valid_q <= 1'b0;
    end else if (cmd_i.upd && sel_i) begin
      valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd && !cmd_i.clr) begin
      if (sel_i) begin
        age_q <= '0;
        if (cmd_i.wr_val) value_q <= cmd_i.value;
        if (cmd_i.ld_key) key_q <= cmd_i.key;
      end else if (valid_q && ({1'b0, age_q} < cmd_i.thr)) begin
        age_q <= age_q + 1'b1;
      end
    end
  end

  assign stat_o.valid  = valid_q;
  assign stat_o.match  = valid_q && (key_q == cmd_i.key);
  assign stat_o.victim = valid_q && (age_q == cmd_i.lru_age);
  assign stat_o.age    = age_q;
  assign stat_o.value  = value_q;

endmodule

// ----- rtl/lru_key_value_cache.sv -----
// Fully associative key-value cache with LRU replacement, 16 entries. A word is taken
// whenever start_i is high; busy_o stays low, so one word per cycle is sustained. The
// word is registered, all entries are matched and ages updated in the next cycle, and
// the result is registered again and shows on done_o/hit_o/read_value_o for one cycle.
// The receiver cannot stall; every word gives exactly one result. Writing
// cfg_data_i with cfg_we_i empties the cache and sets the capacity (0 reads as 1, values
// above the entry count saturate); do this only with no word in flight.
module lru_key_value_cache (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic                                mode_i,
  input  logic signed [lkvc_pkg::KEY_BITS-1:0] key_i,
  input  logic [lkvc_pkg::OUT_BITS-1:0]       write_value_i,
  output logic                                done_o,
  output logic                                hit_o,
  output logic [lkvc_pkg::OUT_BITS-1:0]       read_value_o,
  input  logic                                cfg_we_i,
  input  logic [lkvc_pkg::CAP_BITS-1:0]       cfg_data_i
);
  import lkvc_pkg::*;

  logic                  in_vld_q;
  logic                  mode_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] wval_q;
  logic [CNT_W-1:0]      occ_q, occ_d;
  logic [CNT_W-1:0]      cap_q;
  logic                  done_q;
  logic                  hit_q;
  logic [OUT_BITS-1:0]   rdata_q, rdata_d;

  lkvc_cmd_t             cmd;
  lkvc_stat_t            stat [ENTRIES];
  logic [ENTRIES-1:0]    match_v, victim_v, valid_v, free_v, free_oh, sel_v;
  logic [VALUE_BITS-1:0] hit_value;
  logic [AGE_W-1:0]      hit_age;
  logic                  hit, put, full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      done_q   <= 1'b0;
      occ_q    <= '0;
      cap_q    <= eff_cap(CAP_BITS'(CAP_RESET));
    end else begin
      in_vld_q <= start_i;
      done_q   <= in_vld_q;
      occ_q    <= occ_d;
      if (cfg_we_i) cap_q <= eff_cap(cfg_data_i);
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q  <= mode_i;
    key_q   <= key_i;
    wval_q  <= write_value_i[VALUE_BITS-1:0];
    hit_q   <= hit;
    rdata_q <= rdata_d;
  end

  always_comb begin
    match_v   = '0;
    victim_v  = '0;
    valid_v   = '0;
    hit_value = '0;
    hit_age   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match_v[i]  = stat[i].match;
      victim_v[i] = stat[i].victim;
      valid_v[i]  = stat[i].valid;
      hit_value   = hit_value | (stat[i].value & {VALUE_BITS{stat[i].match}});
      hit_age     = hit_age | (stat[i].age & {AGE_W{stat[i].match}});
    end
  end

  assign hit     = |match_v;
  assign put     = (mode_q == MODE_PUT);
  assign full    = (occ_q >= cap_q);
  assign free_v  = ~valid_v;
  assign free_oh = free_v & (~free_v + 1'b1);

  always_comb begin
    cmd.clr     = cfg_we_i;
    cmd.upd     = in_vld_q && (hit || put);
    cmd.wr_val  = put;
    cmd.ld_key  = put && !hit;
    cmd.key     = key_q;
    cmd.value   = wval_q;
    cmd.lru_age = AGE_W'(occ_q - 1'b1);
    if (hit) begin
      cmd.thr = {1'b0, hit_age};
      sel_v   = match_v;
    end else if (full) begin
      cmd.thr = {1'b0, cmd.lru_age};
      sel_v   = victim_v;
    end else begin
      cmd.thr = (AGE_W + 1)'(ENTRIES);
      sel_v   = free_oh;
    end
  end

  always_comb begin
    occ_d = occ_q;
    if (cfg_we_i) begin
      occ_d = '0;
    end else if (in_vld_q && put && !hit && !full) begin
      occ_d = occ_q + 1'b1;
    end
  end

  assign rdata_d = (!put && hit) ? OUT_BITS'(hit_value) : '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_entry
    lkvc_entry u_entry (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd),
      .sel_i  (sel_v[g]),
      .stat_o (stat[g])
    );
  end

  assign busy_o       = 1'b0;
  assign done_o       = done_q;
  assign hit_o        = hit_q;
  assign read_value_o = rdata_q;

endmodule

// ----- rtl/lkvc_checker.sv -----
module lkvc_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                start_i,
  input logic                                busy_o,
  input logic                                mode_i,
  input logic signed [lkvc_pkg::KEY_BITS-1:0] key_i,
  input logic [lkvc_pkg::OUT_BITS-1:0]       write_value_i,
  input logic                                done_o,
  input logic                                hit_o,
  input logic [lkvc_pkg::OUT_BITS-1:0]       read_value_o,
  input logic                                cfg_we_i
);
  import lkvc_pkg::*;

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##2 done_o)
    else $error("accepted word gave no result");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 2))
    else $error("result without accepted word");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (!hit_o || $past(mode_i, 2) == MODE_PUT)) |-> (read_value_o == '0))
    else $error("nonzero read value on miss or put");

  a_put_get: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && mode_i == MODE_GET && !cfg_we_i &&
     $past(start_i && !busy_o && mode_i == MODE_PUT) && key_i == $past(key_i))
    |-> ##2 (hit_o && read_value_o == $past(write_value_i, 3)))
    else $error("get after put of same key missed");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (.*);
